### rtl/core/mf3_pkg.sv
// Shared types, constants and helpers of the 3x3 maximum filter.
// No dependencies; every other file of the filter refers to it by scoped names.
package mf3_pkg;

  localparam int CHAN_W  = 8;
  localparam int CHANS   = 3;
  localparam int PIX_W   = CHAN_W * CHANS;
  localparam int TAPS    = 9;
  localparam int CENTER  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_CHANNEL = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // per-item position flags, decided when the item enters
  typedef struct packed {
    logic emit;    // item completes the neighborhood of an output pixel
    logic border;  // that output pixel lies on the frame border
    logic last;    // that output pixel is the last of the frame
  } flags_t;

  function automatic chan_t max9(input logic [TAPS-1:0][CHAN_W-1:0] v);
    chan_t m;
    m = v[0];
    for (int i = 1; i < TAPS; i++) begin
      if (v[i] > m) m = v[i];
    end
    return m;
  endfunction

endpackage

### rtl/core/max_filter_3x3.sv
// Top level of the 3x3 maximum filter on a raster pixel stream.
// Depends on mf3_pkg, mf3_ctrl, mf3_line_store and mf3_window.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  pixel in | in_valid_i / in_stall_o     | chan0_i chan1_i chan2_i drain_i
//  result   | out_valid_o / out_stall_i   | out0_o out1_o out2_o frame_end_o
//  config   | cfg_valid_i / cfg_ready_o   | cfg_index_i cfg_data_i
//
// One beat per cycle unless a result is stalled; the beat that completes a neighborhood
// is registered with its line store reads, shifts into the window, and its per-channel
// maximum loads the result register for output. A pixel's result comes with the beat
// frame_width+1 positions later, so that many drain beats flush a frame. A stalled
// result holds the whole pipeline and stalls the input in the same cycle. Reset loads
// the register defaults and clears counters and valid bits; line stores are not
// cleared, as unwritten entries only reach border positions.
module max_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      chan0_i,
  input  logic [7:0]                      chan1_i,
  input  logic [7:0]                      chan2_i,
  input  logic                            drain_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out0_o,
  output logic [7:0]                      out1_o,
  output logic [7:0]                      out2_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic            en;
  logic            accept;
  logic            take;
  logic            in_frame;
  logic            three_channel;
  logic [CW-1:0]   col;
  mf3_pkg::flags_t flags;
  mf3_pkg::pix_t   pix;
  mf3_pkg::pix_t   top_rd, mid_rd;

  logic            s1_valid_q;
  mf3_pkg::pix_t   s1_pix_q;
  logic [CW-1:0]   s1_col_q;
  mf3_pkg::flags_t s1_flags_q;

  // advance every stage unless a finished result is held
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  mf3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .drain_i         (drain_i),
    .take_o          (take),
    .in_frame_o      (in_frame),
    .col_o           (col),
    .flags_o         (flags),
    .three_channel_o (three_channel)
  );

  // flush beats and single-channel upper bytes enter as zero
  always_comb begin
    pix = '0;
    if (in_frame && !drain_i) begin
      pix[7:0] = chan0_i;
      if (three_channel) begin
        pix[15:8]  = chan1_i;
        pix[23:16] = chan2_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && take) begin
      s1_pix_q   <= pix;
      s1_col_q   <= col;
      s1_flags_q <= flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= take;
    end
  end

  // store a: row two above; store b: row above
  mf3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store_a (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (col),
    .rd_data_o (top_rd),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (mid_rd)
  );

  mf3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store_b (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (col),
    .rd_data_o (mid_rd),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_pix_q)
  );

  mf3_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (s1_valid_q),
    .flags_i         (s1_flags_q),
    .top_i           (top_rd),
    .mid_i           (mid_rd),
    .pix_i           (s1_pix_q),
    .three_channel_i (three_channel),
    .out_valid_o     (out_valid_o),
    .out0_o          (out0_o),
    .out1_o          (out1_o),
    .out2_o          (out2_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

### rtl/core/mf3_line_store.sv
// One line buffer of the 3x3 maximum filter: one write port, one registered read port.
// Depends on mf3_pkg for the pixel width.
module mf3_line_store #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output mf3_pkg::pix_t       rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  mf3_pkg::pix_t       wr_data_i
);

  mf3_pkg::pix_t mem_q [DEPTH];
  mf3_pkg::pix_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/mf3_ctrl.sv
// Configuration registers and raster position counters of the 3x3 maximum filter.
// Depends on mf3_pkg for register codes, reset values and the flag struct.
module mf3_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  logic                            drain_i,
  output logic                            take_o,
  output logic                            in_frame_o,
  output logic [CW-1:0]                   col_o,
  output mf3_pkg::flags_t                 flags_o,
  output logic                            three_channel_o
);

  function automatic logic [CW-1:0] width_last(input logic [mf3_pkg::WIDTH_W-1:0] v);
    int unsigned val;
    val = v;
    if (val < 3) val = 3;
    if (val > MAX_WIDTH) val = MAX_WIDTH;
    return CW'(val - 1);
  endfunction

  function automatic logic [RW-1:0] height_clamp(input logic [mf3_pkg::HEIGHT_W-1:0] v);
    int unsigned val;
    val = v;
    if (val < 3) val = 3;
    if (val > MAX_HEIGHT) val = MAX_HEIGHT;
    return RW'(val);
  endfunction

  logic [CW-1:0] w_last_q;
  logic [RW-1:0] h_q;
  logic          three_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          cfg_hit;
  logic          col0, col1;

  always_comb begin
    case (cfg_index_i)
      mf3_pkg::CFG_FRAME_WIDTH,
      mf3_pkg::CFG_FRAME_HEIGHT,
      mf3_pkg::CFG_THREE_CHANNEL: cfg_hit = cfg_valid_i;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= width_last(mf3_pkg::WIDTH_RESET);
      h_q      <= height_clamp(mf3_pkg::HEIGHT_RESET);
      three_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mf3_pkg::CFG_FRAME_WIDTH:   w_last_q <= width_last(cfg_data_i[mf3_pkg::WIDTH_W-1:0]);
        mf3_pkg::CFG_FRAME_HEIGHT:  h_q      <= height_clamp(cfg_data_i);
        mf3_pkg::CFG_THREE_CHANNEL: three_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign col0       = (col_q == '0);
  assign col1       = (col_q == CW'(1));
  assign in_frame_o = (row_q < h_q);
  // drop drain beats that arrive before the frame is complete
  assign take_o     = accept_i && !(drain_i && in_frame_o);

  assign flags_o.emit   = (row_q >= RW'(2)) || ((row_q == RW'(1)) && !col0);
  assign flags_o.border = col0 || col1 || (row_q == RW'(1)) || (row_q == h_q);
  assign flags_o.last   = col0 && (row_q == RW'(h_q + RW'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (take_o) begin
      if (flags_o.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == w_last_q) begin
        col_d = '0;
        row_d = RW'(row_q + RW'(1));
      end else begin
        col_d = CW'(col_q + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o           = col_q;
  assign three_channel_o = three_q;

  // column never passes the row end
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q <= w_last_q)
    else $error("column counter beyond row end");

  // row never passes the second flush row
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q <= RW'(h_q + RW'(1)))
    else $error("row counter beyond flush rows");

  // the last pixel of a frame restarts the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && flags_o.last |=> (col_q == '0) && (row_q == '0))
    else $error("frame did not restart after its last pixel");

endmodule

### rtl/core/mf3_window.sv
// 3x3 window registers, per-channel maximum, border bypass and result register.
// Depends on mf3_pkg for the pixel type, the flag struct and the max9 helper.
module mf3_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  mf3_pkg::flags_t        flags_i,
  input  mf3_pkg::pix_t          top_i,
  input  mf3_pkg::pix_t          mid_i,
  input  mf3_pkg::pix_t          pix_i,
  input  logic                   three_channel_i,
  output logic                   out_valid_o,
  output mf3_pkg::chan_t         out0_o,
  output mf3_pkg::chan_t         out1_o,
  output mf3_pkg::chan_t         out2_o,
  output logic                   frame_end_o
);

  mf3_pkg::pix_t   win_q [mf3_pkg::TAPS];
  logic            s2_valid_q;
  mf3_pkg::flags_t s2_flags_q;
  logic            out_valid_q;
  mf3_pkg::pix_t   res_q;
  logic            frame_end_q;
  mf3_pkg::pix_t   max_pix;
  mf3_pkg::pix_t   res;

  always_comb begin
    logic [mf3_pkg::TAPS-1:0][mf3_pkg::CHAN_W-1:0] taps;
    for (int c = 0; c < mf3_pkg::CHANS; c++) begin
      for (int t = 0; t < mf3_pkg::TAPS; t++) begin
        taps[t] = win_q[t][c*mf3_pkg::CHAN_W +: mf3_pkg::CHAN_W];
      end
      max_pix[c*mf3_pkg::CHAN_W +: mf3_pkg::CHAN_W] = mf3_pkg::max9(taps);
    end
  end

  always_comb begin
    res = s2_flags_q.border ? win_q[mf3_pkg::CENTER] : max_pix;
    if (!three_channel_i) begin
      res[mf3_pkg::PIX_W-1:mf3_pkg::CHAN_W] = '0;
    end
  end

  // shift the window one column left, newest column enters on the right
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_flags_q <= flags_i;
      if (s2_valid_q && s2_flags_q.emit) begin
        res_q       <= res;
        frame_end_q <= s2_flags_q.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q  <= valid_i;
      out_valid_q <= s2_valid_q && s2_flags_q.emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out0_o      = res_q[0 +: mf3_pkg::CHAN_W];
  assign out1_o      = res_q[mf3_pkg::CHAN_W +: mf3_pkg::CHAN_W];
  assign out2_o      = res_q[2*mf3_pkg::CHAN_W +: mf3_pkg::CHAN_W];
  assign frame_end_o = frame_end_q;

endmodule

### sim/max_filter_3x3_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_filter_3x3: drives pixel beats, predicts each
// filtered pixel with its own line stores and window, and compares every result beat.
// Depends on mf3_pkg and the max_filter_3x3 RTL only.
module max_filter_3x3_test;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 32;
  localparam int RANDOM_ITEMS  = 750;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // index past the last register: writes to it change nothing
  localparam logic [mf3_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic       frame_end;
  } filtered_px_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [7:0]                     chan0_i;
  logic [7:0]                     chan1_i;
  logic [7:0]                     chan2_i;
  logic                           drain_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     out0_o;
  logic [7:0]                     out1_o;
  logic [7:0]                     out2_o;
  logic                           frame_end_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data_i;

  max_filter_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .chan0_i    (chan0_i),
    .chan1_i    (chan1_i),
    .chan2_i    (chan2_i),
    .drain_i    (drain_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out0_o     (out0_o),
    .out1_o     (out1_o),
    .out2_o     (out2_o),
    .frame_end_o(frame_end_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [mf3_pkg::WIDTH_W-1:0]  width_reg;
  logic [mf3_pkg::HEIGHT_W-1:0] height_reg;
  logic                         three_reg;
  logic [23:0]                  two_rows_up [MAX_W];
  logic [23:0]                  one_row_up [MAX_W];
  logic [23:0]                  taps [9];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  logic [22:0]                  out_pos;

  filtered_px_t filtered_due[$];
  int unsigned  mismatches = 0;
  int unsigned  pixels_sent;
  int unsigned  cycles = 0;
  bit           no_idle;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("max_filter_3x3_test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    filtered_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_due.size() == 0) begin
        $error("result beat with no pixel due: out0 %0d out1 %0d out2 %0d frame_end %0d",
               out0_o, out1_o, out2_o, frame_end_o);
        mismatches++;
      end else begin
        want = filtered_due.pop_front();
        if (out0_o !== want.out0) begin
          $error("out0 expected %0d actual %0d", want.out0, out0_o);
          mismatches++;
        end
        if (out1_o !== want.out1) begin
          $error("out1 expected %0d actual %0d", want.out1, out1_o);
          mismatches++;
        end
        if (out2_o !== want.out2) begin
          $error("out2 expected %0d actual %0d", want.out2, out2_o);
          mismatches++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end expected %0d actual %0d", want.frame_end, frame_end_o);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Shift one beat into the line stores and window; queue the filtered pixel it completes.
  task automatic predict_max_window(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic [7:0] c2, input logic dr);
    int unsigned  w;
    int unsigned  h;
    int unsigned  col;
    int unsigned  row;
    int unsigned  oc;
    int unsigned  orow;
    logic [23:0]  pix;
    logic [23:0]  top;
    logic [23:0]  mid;
    logic [23:0]  res;
    logic [7:0]   m;
    logic [7:0]   v;
    bit           border;
    filtered_px_t r;
    w = eff_width();
    h = eff_height();
    // drain while the frame still takes pixels: nothing happens
    if (dr && row_pos < h) return;
    pix = '0;
    // pixels past the frame act as drains
    if (!dr && row_pos < h) begin
      pix[7:0] = c0;
      if (three_reg) pix[23:8] = {c2, c1};
    end
    col = col_pos;
    row = row_pos;
    top = two_rows_up[col];
    mid = one_row_up[col];
    two_rows_up[col] = mid;
    one_row_up[col] = pix;
    for (int i = 0; i < 3; i++) begin
      taps[i*3]   = taps[i*3+1];
      taps[i*3+1] = taps[i*3+2];
    end
    taps[2] = top;
    taps[5] = mid;
    taps[8] = pix;
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
    end
    if (!(row >= 2 || (row == 1 && col >= 1))) return;
    if (col == 0) begin
      oc = w - 1;
      orow = row - 2;
    end else begin
      oc = col - 1;
      orow = row - 1;
    end
    border = orow == 0 || orow == h - 1 || oc == 0 || oc == w - 1;
    if (border) begin
      res = taps[4];
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        m = '0;
        for (int i = 0; i < 9; i++) begin
          v = taps[i][8*ch +: 8];
          if (v > m) m = v;
        end
        res[8*ch +: 8] = m;
      end
    end
    if (!three_reg) res[23:8] = '0;
    r.out0 = res[7:0];
    r.out1 = res[15:8];
    r.out2 = res[23:16];
    r.frame_end = out_pos == 23'(w * h - 1);
    out_pos = out_pos + 1'b1;
    if (r.frame_end) begin
      col_pos = 0;
      row_pos = 0;
      out_pos = '0;
    end
    filtered_due.push_back(r);
  endtask

  // Offer one beat from a falling edge; return at the falling edge after it is taken.
  task automatic push_beat(input logic [7:0] c0, input logic [7:0] c1,
                           input logic [7:0] c2, input logic dr);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    chan0_i    <= c0;
    chan1_i    <= c1;
    chan2_i    <= c2;
    drain_i    <= dr;
    do @(posedge clk_i); while (in_stall_o);
    predict_max_window(c0, c1, c2, dr);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_due.size() != 0) @(negedge clk_i);
    // beats that complete no pixel may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mf3_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mf3_pkg::CFG_FRAME_WIDTH:   width_reg = data[mf3_pkg::WIDTH_W-1:0];
      mf3_pkg::CFG_FRAME_HEIGHT:  height_reg = data;
      mf3_pkg::CFG_THREE_CHANNEL: three_reg = data[0];
      default: ;
    endcase
    // any real register write restarts the frame
    if (idx != CFG_UNMAPPED) begin
      col_pos = 0;
      row_pos = 0;
      out_pos = '0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send n random pixels with stray drains mixed in; flush the frame when asked.
  task automatic run_frame(input int unsigned n, input bit flush);
    int unsigned w;
    w = eff_width();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) push_beat(rand_chan(), rand_chan(), rand_chan(), 1'b1);
      push_beat(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      pixels_sent++;
    end
    if (flush) begin
      for (int unsigned j = 0; j <= w; j++) begin
        push_beat(rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(1)));
        pixels_sent++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    // 640 wide, single channel out of reset: one row and a bit
    run_frame(640 + 16, 1'b0);
  endtask

  task automatic test_directed_corners();
    logic [23:0] corner_px [9];
    corner_px = '{24'h000000, 24'hFF0001, 24'h807F00, 24'h01FF00, 24'h55AA10,
                  24'h0000FE, 24'hAA55FF, 24'h7F8000, 24'h0001FF};
    // out-of-range sizes clamp to 3x3; only bit 0 of the channel register counts
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd1);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd2);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'h1FFF);
    push_beat(8'hFF, 8'hFF, 8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) begin
      push_beat(corner_px[i][7:0], corner_px[i][15:8], corner_px[i][23:16], 1'b0);
    end
    // flush with drains and with pixels past the frame
    for (int j = 0; j < 4; j++) push_beat(8'hFF, 8'h00, 8'hAA, j % 2 == 0);
    // dark center in a white frame
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_beat(8'h00, 8'h00, 8'h00, 1'b0);
      else push_beat(8'hFF, 8'hFF, 8'hFF, 1'b0);
    end
    for (int j = 0; j < 4; j++) push_beat(8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_config_sweep();
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd4);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd4);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'd0);
    run_frame(16, 1'b1);
    // upper data bits of the width are dropped
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'h1805);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd0);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'h1FFE);
    run_frame(15, 1'b1);
    run_frame(15, 1'b1);
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd6);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd5);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'd1);
    run_frame(13, 1'b0);
    // unmapped index: the frame carries on where it stopped
    write_reg(CFG_UNMAPPED, 13'h1FFF);
    run_frame(17, 1'b1);
    run_frame(20, 1'b0);
    // abandon mid-frame: the write restarts it
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd1);
    run_frame(18, 1'b1);
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'h1803);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd7);
    run_frame(21, 1'b1);
  endtask

  task automatic test_widest_frame();
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'd3);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'd1);
    // well short of one clamped row: no result may appear
    run_frame(40, 1'b0);
  endtask

  task automatic test_tallest_frame();
    write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'd3);
    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'd0);
    // twenty rows into the clamped height: no frame end may appear
    run_frame(60, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned w_pick;
    int unsigned h_pick;
    int unsigned n_frames;
    bit          cut;
    start = pixels_sent;
    cut = 1'b0;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      no_idle = (pixels_sent - start >= 200) && (pixels_sent - start < 600);
      w_pick = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 16);
      h_pick = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
      // an abandoned frame must be restarted by a write
      if (cut || $urandom_range(99) < 80) begin
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, 13'($urandom & 32'h1800) | 13'(w_pick));
      end
      // the first pass leaves the tall frame behind
      if (pixels_sent == start || $urandom_range(99) < 80) begin
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, 13'(h_pick));
      end
      if ($urandom_range(99) < 80) write_reg(mf3_pkg::CFG_THREE_CHANNEL, 13'($urandom));
      cut = 1'b0;
      n_frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < n_frames && !cut; f++) begin
        if ($urandom_range(99) < 10) begin
          run_frame($urandom_range(1, eff_width() * eff_height() - 1), 1'b0);
          cut = 1'b1;
        end else begin
          run_frame(eff_width() * eff_height(), 1'b1);
        end
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    chan0_i     = '0;
    chan1_i     = '0;
    chan2_i     = '0;
    drain_i     = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mf3_pkg::CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    pixels_sent = 0;
    width_reg   = mf3_pkg::WIDTH_RESET;
    height_reg  = mf3_pkg::HEIGHT_RESET;
    three_reg   = 1'b0;
    col_pos     = 0;
    row_pos     = 0;
    out_pos     = '0;
    for (int i = 0; i < MAX_W; i++) begin
      two_rows_up[i] = '0;
      one_row_up[i]  = '0;
    end
    for (int i = 0; i < 9; i++) taps[i] = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed_corners();
    test_config_sweep();
    test_widest_frame();
    test_tallest_frame();
    test_random_frames();

    wait_drained();
    if (mismatches == 0) begin
      $display("max_filter_3x3_test passed");
    end else begin
      $display("max_filter_3x3_test failed");
    end
    $finish;
  end

endmodule
